@@ sv/abkf_pkg.sv @@
// ----------------------------------------------------------------------------
// abkf_pkg
// Types, constants and fixed-point helpers for the angle/bias Kalman filter.
// ----------------------------------------------------------------------------
`default_nettype none

package abkf_pkg;

  localparam int unsigned NoiseW = 28;
  localparam int unsigned AddrW  = 4;
  localparam int unsigned DataW  = 32;

  localparam logic [NoiseW-1:0] QaReset = 28'd16777;
  localparam logic [NoiseW-1:0] QbReset = 28'd50332;
  localparam logic [NoiseW-1:0] RReset  = 28'd503316;

  localparam logic [31:0] S32Max = 32'h7fff_ffff;
  localparam logic [31:0] S32Min = 32'h8000_0000;

  typedef enum logic [0:0] {
    CMD_UPDATE    = 1'b0,
    CMD_SET_ANGLE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    REG_QA = 2'd0,
    REG_QB = 2'd1,
    REG_R  = 2'd2
  } reg_e;

  typedef struct packed {
    logic               command;
    logic signed [31:0] measured_angle;
    logic signed [31:0] gyro_rate;
    logic        [15:0] time_step;
  } abkf_in_t;

  typedef struct packed {
    logic signed [31:0] angle_estimate;
    logic signed [31:0] rate_estimate;
    logic signed [31:0] bias_estimate;
  } abkf_out_t;

  // request to the divider
  typedef struct packed {
    logic               start;
    logic signed [31:0] num;
    logic        [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] quot;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RATE,
    ST_MUL,
    ST_ACC,
    ST_PRED,
    ST_SCHK,
    ST_K0GO,
    ST_K0WAIT,
    ST_K1GO,
    ST_K1WAIT,
    ST_YERR,
    ST_OUT
  } state_e;

  typedef enum logic [3:0] {
    OP_ANG_PRED,
    OP_DP11,
    OP_P00_PRED,
    OP_P11_PRED,
    OP_ANG_CORR,
    OP_BIAS_CORR,
    OP_P10_CORR,
    OP_P11_CORR,
    OP_P00_CORR,
    OP_P01_CORR
  } op_e;

  function automatic logic signed [31:0] sat32(input logic signed [69:0] v);
    logic signed [31:0] r;
    if (v > 70'sh0_7fff_ffff) begin
      r = S32Max;
    end else if (v < -70'sh0_8000_0000) begin
      r = S32Min;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // round to nearest, ties up, by 16 or 24 bits
  function automatic logic signed [67:0] rnd_sh(input logic signed [67:0] x,
                                                input logic sh24);
    logic signed [68:0] t;
    t = {x[67], x} + (sh24 ? 69'sd8388608 : 69'sd32768);
    return sh24 ? 68'(t >>> 24) : 68'(t >>> 16);
  endfunction

endpackage

`default_nettype wire

@@ sv/abkf_div.sv @@
// ----------------------------------------------------------------------------
// abkf_div
// Radix-2 restoring divider: sat32((num << 24) / den), truncating toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module abkf_div
  import abkf_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  logic        busy_q, done_q, neg_q, ovf_q;
  logic [4:0]  cnt_q;
  logic [31:0] rem_q, sh_q, den_q;
  logic [31:0] mag;
  logic [23:0] hi;
  logic [32:0] trial;
  logic        fits;
  logic [31:0] q;

  assign mag   = req_i.num[31] ? 32'(-req_i.num) : req_i.num;
  assign hi    = mag[31:8];
  assign trial = {rem_q, sh_q[31]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      den_q <= req_i.den;
      neg_q <= req_i.num[31];
      // quotient would need more than 32 bits
      ovf_q <= {8'd0, hi} >= req_i.den;
      rem_q <= {8'd0, hi};
      sh_q  <= {mag[7:0], 24'd0};
    end else if (busy_q) begin
      rem_q <= fits ? 32'(trial - {1'b0, den_q}) : trial[31:0];
      sh_q  <= {sh_q[30:0], fits};
    end
  end

  assign q = sh_q;

  always_comb begin
    rsp_o.done = done_q;
    if (!neg_q) begin
      rsp_o.quot = (ovf_q || q[31]) ? S32Max : q;
    end else begin
      rsp_o.quot = (ovf_q || (q[31] && |q[30:0])) ? S32Min : 32'(-q);
    end
  end

endmodule

`default_nettype wire

@@ sv/angle_bias_kalman_filter_unit.sv @@
// ----------------------------------------------------------------------------
// angle_bias_kalman_filter_unit
// Two-state angle / gyro-bias Kalman filter, fixed point, sequenced datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_req_i) takes one request:
//   a filter update or a set-angle command. Output channel (out_valid_o /
//   out_stall_i / out_rsp_o) returns angle, rate and bias for each request.
//   Noise registers sit on the APB port at 0x0, 0x4, 0x8; write them only
//   while the unit is idle.
// Sequencing:
//   An update uses one shared 35x33 multiplier for ten multiply/round/
//   accumulate steps (a multiply state, then an accumulate state) and a
//   1-bit-per-cycle divider that forms both gains. If the innovation
//   variance is not positive the gains and correction steps are skipped.
//   A set-angle request returns its result in the cycle after accept.
//   One request is in flight at a time; in_stall_o is high until the
//   result is taken, and the next request is taken in the cycle after.
// Reset: estimates and covariance clear to zero, noise registers go to
//   their defaults. A stalled result is held until out_stall_i drops.
// ----------------------------------------------------------------------------
`default_nettype none

module angle_bias_kalman_filter_unit
  import abkf_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire abkf_in_t         in_req_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output abkf_out_t             out_rsp_o,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready
);

  state_e state_q, state_d;
  op_e    op_q, op_d;

  logic [NoiseW-1:0] qa_q, qb_q, r_q;

  logic signed [31:0] angle_q, bias_q, rate_q;
  logic signed [31:0] p00_q, p01_q, p10_q, p11_q;
  logic signed [31:0] meas_q, gyro_q, k0_q, k1_q, y_q;
  logic        [15:0] dt_q;
  logic signed [32:0] dp11_q;
  logic signed [34:0] inner_q;
  logic        [31:0] s_q;
  logic signed [67:0] prod_q;

  logic signed [34:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [67:0] prod_d;
  logic signed [67:0] rnd;
  logic signed [69:0] acc_base, acc_sum;
  logic               acc_sub;
  logic signed [31:0] acc_res;
  logic signed [33:0] s_full;
  logic               accept, wr_en;
  reg_e               wr_idx;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  assign accept = in_valid_i && !in_stall_o;

  // APB registers
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign wr_idx = reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qa_q <= QaReset;
      qb_q <= QbReset;
      r_q  <= RReset;
    end else if (wr_en) begin
      case (wr_idx)
        REG_QA:  qa_q <= pwdata[NoiseW-1:0];
        REG_QB:  qb_q <= pwdata[NoiseW-1:0];
        REG_R:   r_q  <= pwdata[NoiseW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (wr_idx)
      REG_QA:  prdata = {{(DataW-NoiseW){1'b0}}, qa_q};
      REG_QB:  prdata = {{(DataW-NoiseW){1'b0}}, qb_q};
      REG_R:   prdata = {{(DataW-NoiseW){1'b0}}, r_q};
      default: prdata = '0;
    endcase
  end

  // shared multiplier operands
  always_comb begin
    case (op_q)
      OP_ANG_PRED:  mul_a = 35'(rate_q);
      OP_DP11:      mul_a = 35'(p11_q);
      OP_P00_PRED:  mul_a = inner_q;
      OP_P11_PRED:  mul_a = {7'd0, qb_q};
      OP_ANG_CORR,
      OP_BIAS_CORR: mul_a = 35'(y_q);
      OP_P10_CORR,
      OP_P00_CORR:  mul_a = 35'(p00_q);
      OP_P11_CORR,
      OP_P01_CORR:  mul_a = 35'(p01_q);
      default:      mul_a = '0;
    endcase
    case (op_q)
      OP_ANG_PRED, OP_DP11, OP_P00_PRED, OP_P11_PRED: mul_b = {17'd0, dt_q};
      OP_ANG_CORR, OP_P00_CORR, OP_P01_CORR:          mul_b = 33'(k0_q);
      OP_BIAS_CORR, OP_P10_CORR, OP_P11_CORR:         mul_b = 33'(k1_q);
      default:                                        mul_b = '0;
    endcase
  end

  assign prod_d = mul_a * mul_b;
  assign rnd    = rnd_sh(prod_q, op_q >= OP_ANG_CORR);

  // accumulate target and direction
  always_comb begin
    acc_sub = 1'b0;
    case (op_q)
      OP_ANG_PRED, OP_ANG_CORR: acc_base = 70'(angle_q);
      OP_BIAS_CORR:             acc_base = 70'(bias_q);
      OP_P00_PRED:              acc_base = 70'(p00_q);
      OP_P11_PRED:              acc_base = 70'(p11_q);
      OP_P10_CORR: begin
        acc_base = 70'(p10_q);
        acc_sub  = 1'b1;
      end
      OP_P11_CORR: begin
        acc_base = 70'(p11_q);
        acc_sub  = 1'b1;
      end
      OP_P00_CORR: begin
        acc_base = 70'(p00_q);
        acc_sub  = 1'b1;
      end
      OP_P01_CORR: begin
        acc_base = 70'(p01_q);
        acc_sub  = 1'b1;
      end
      default:                  acc_base = '0;
    endcase
  end

  assign acc_sum = acc_sub ? acc_base - 70'(rnd) : acc_base + 70'(rnd);
  assign acc_res = sat32(acc_sum);
  assign s_full  = 34'(p00_q) + {6'd0, r_q};

  // next state
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (in_req_i.command == CMD_SET_ANGLE) ? ST_OUT : ST_RATE;
        end
      end
      ST_RATE: begin
        state_d = ST_MUL;
        op_d    = OP_ANG_PRED;
      end
      ST_MUL:  state_d = ST_ACC;
      ST_ACC: begin
        case (op_q)
          OP_DP11:     state_d = ST_PRED;
          OP_P11_PRED: state_d = ST_SCHK;
          OP_P01_CORR: state_d = ST_OUT;
          default: begin
            state_d = ST_MUL;
            op_d    = op_e'(4'(op_q + 4'd1));
          end
        endcase
      end
      ST_PRED: begin
        state_d = ST_MUL;
        op_d    = OP_P00_PRED;
      end
      ST_SCHK: begin
        // non-positive innovation variance: no correction
        state_d = (s_full[33] || s_full == '0) ? ST_OUT : ST_K0GO;
      end
      ST_K0GO:   state_d = ST_K0WAIT;
      ST_K0WAIT: if (div_rsp.done) state_d = ST_K1GO;
      ST_K1GO:   state_d = ST_K1WAIT;
      ST_K1WAIT: if (div_rsp.done) state_d = ST_YERR;
      ST_YERR: begin
        state_d = ST_MUL;
        op_d    = OP_ANG_CORR;
      end
      ST_OUT:  if (!out_stall_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall_o    = state_q != ST_IDLE;
    out_valid_o   = state_q == ST_OUT;
    div_req.start = (state_q == ST_K0GO) || (state_q == ST_K1GO);
    div_req.num   = (state_q == ST_K1GO) ? p10_q : p00_q;
    div_req.den   = s_q;
  end

  assign out_rsp_o.angle_estimate = angle_q;
  assign out_rsp_o.rate_estimate  = rate_q;
  assign out_rsp_o.bias_estimate  = bias_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_ANG_PRED;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  // filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q <= '0;
      bias_q  <= '0;
      rate_q  <= '0;
      p00_q   <= '0;
      p01_q   <= '0;
      p10_q   <= '0;
      p11_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept && in_req_i.command == CMD_SET_ANGLE) begin
            angle_q <= in_req_i.measured_angle;
          end
        end
        ST_RATE: rate_q <= sat32(70'(gyro_q) - 70'(bias_q));
        ST_PRED: begin
          p01_q <= sat32(70'(p01_q) - 70'(dp11_q));
          p10_q <= sat32(70'(p10_q) - 70'(dp11_q));
        end
        ST_ACC: begin
          case (op_q)
            OP_ANG_PRED, OP_ANG_CORR: angle_q <= acc_res;
            OP_BIAS_CORR:             bias_q  <= acc_res;
            OP_P00_PRED, OP_P00_CORR: p00_q   <= acc_res;
            OP_P11_PRED, OP_P11_CORR: p11_q   <= acc_res;
            OP_P10_CORR:              p10_q   <= acc_res;
            OP_P01_CORR:              p01_q   <= acc_res;
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      meas_q <= in_req_i.measured_angle;
      gyro_q <= in_req_i.gyro_rate;
      dt_q   <= in_req_i.time_step;
    end
    if (state_q == ST_MUL) begin
      prod_q <= prod_d;
    end
    if (state_q == ST_ACC && op_q == OP_DP11) begin
      dp11_q <= rnd[32:0];
    end
    if (state_q == ST_PRED) begin
      inner_q <= 35'(dp11_q) - 35'(p01_q) - 35'(p10_q) + {7'd0, qa_q};
    end
    if (state_q == ST_SCHK) begin
      s_q <= s_full[31:0];
    end
    if (state_q == ST_K0WAIT && div_rsp.done) begin
      k0_q <= div_rsp.quot;
    end
    if (state_q == ST_K1WAIT && div_rsp.done) begin
      k1_q <= div_rsp.quot;
    end
    if (state_q == ST_YERR) begin
      y_q <= sat32(70'(meas_q) - 70'(angle_q));
    end
  end

  abkf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

endmodule

`default_nettype wire

@@ sv/abkf_checker.sv @@
// ----------------------------------------------------------------------------
// abkf_checker
// Port-level checks for the angle/bias Kalman filter unit.
// ----------------------------------------------------------------------------
`default_nettype none

module abkf_checker
  import abkf_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_stall_o,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire abkf_out_t out_rsp_o
);

  // a pending result keeps the input side closed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while result pending");

  // one request in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second request taken while busy");

  // a taken result is not shown again
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i) |=> !out_valid_o)
    else $error("result repeated");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_rsp_o)))
    else $error("stalled result changed");

endmodule

bind angle_bias_kalman_filter_unit abkf_checker u_abkf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_rsp_o   (out_rsp_o)
);

`default_nettype wire
